FILE: rtl/rip_pkg.sv
// ----------------------------------------------------------------------------
// rip_pkg: shared definitions for the reference-counted index pool
// Pool geometry, command codes and status codes.
// ----------------------------------------------------------------------------
package rip_pkg;

  localparam int POOL_SIZE   = 16;
  localparam int COUNT_WIDTH = 8;
  localparam int IDX_W       = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int FILL_W      = $clog2(POOL_SIZE + 1);
  localparam int SLOT_W      = 8;
  localparam int GRANT_W     = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_ADD_REF = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FAIL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

endpackage

FILE: rtl/refcounted_index_pool_unit.sv
// ----------------------------------------------------------------------------
// refcounted_index_pool_unit: slot allocator with per-slot reference counts
// A request accepted while idle moves the unit to its execute state, where
// busy is high for one cycle; done and the result are registered as that
// state ends. No new request is taken while busy, as the free-list and count
// memories are read at acceptance and modified and written back in that state.
// Reset clears pointers and per-entry valid bits at once, so the pool is
// ready in the first cycle after reset with no clearing pass.
// ----------------------------------------------------------------------------
module refcounted_index_pool_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [rip_pkg::SLOT_W-1:0]   slot_index,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [rip_pkg::GRANT_W-1:0]  granted_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import rip_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  state_t                 state;
  logic                   zero_release_error;
  logic [IDX_W-1:0]       free_head;
  logic [IDX_W-1:0]       free_tail;
  logic [FILL_W-1:0]      free_fill;
  logic [IDX_W-1:0]       free_head_next;
  logic [IDX_W-1:0]       free_tail_next;
  logic [FILL_W-1:0]      free_fill_next;

  logic [IDX_W-1:0]       free_mem  [POOL_SIZE];
  logic [COUNT_WIDTH-1:0] count_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0]   free_valid;
  logic [POOL_SIZE-1:0]   count_valid;

  logic [1:0]             cmd_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [IDX_W-1:0]       free_rdata;
  logic                   free_rvalid;
  logic [COUNT_WIDTH-1:0] count_rdata;
  logic                   count_rvalid;

  logic                   accept;
  logic [IDX_W-1:0]       slot_idx;
  logic                   idx_ok;
  logic [IDX_W-1:0]       head_entry;
  logic [IDX_W-1:0]       grant;
  logic [COUNT_WIDTH-1:0] count_cur;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic                   count_we;
  logic [IDX_W-1:0]       count_waddr;
  logic [COUNT_WIDTH-1:0] count_wdata;
  logic                   free_we;
  status_t                status_next;
  logic [GRANT_W-1:0]     granted_next;

  function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
    next_pos = ({1'b0, p} + 1'b1 >= (IDX_W+1)'(POOL_SIZE)) ? '0 : IDX_W'(p + 1'b1);
  endfunction

  assign busy      = (state == S_EXEC);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign slot_idx  = slot_q[IDX_W-1:0];
  assign idx_ok    = ({1'b0, slot_q} < (SLOT_W+1)'(POOL_SIZE));

  // Entries never written read as their reset contents.
  assign head_entry = free_rvalid ? free_rdata : free_head;
  assign grant      = ({1'b0, head_entry} >= (IDX_W+1)'(POOL_SIZE)) ? '0 : head_entry;
  assign count_cur  = count_rvalid ? count_rdata : '0;
  assign count_dec  = count_cur - 1'b1;

  always_comb begin
    status_next    = ST_FAIL;
    granted_next   = '0;
    count_we       = 1'b0;
    count_waddr    = slot_idx;
    count_wdata    = count_cur;
    free_we        = 1'b0;
    free_head_next = free_head;
    free_tail_next = free_tail;
    free_fill_next = free_fill;
    unique case (cmd_q)
      CMD_ALLOC: begin
        if (free_fill != '0) begin
          status_next    = ST_OK;
          granted_next   = GRANT_W'(grant);
          count_we       = 1'b1;
          count_waddr    = grant;
          count_wdata    = COUNT_WIDTH'(1);
          free_head_next = next_pos(free_head);
          free_fill_next = free_fill - 1'b1;
        end
      end
      CMD_ADD_REF: begin
        if (idx_ok && count_cur != COUNT_MAX) begin
          status_next = ST_OK;
          count_we    = 1'b1;
          count_wdata = count_cur + 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (idx_ok) begin
          if (count_cur == '0) begin
            status_next = zero_release_error ? ST_ZERO : ST_OK;
          end else begin
            status_next = ST_OK;
            count_we    = 1'b1;
            count_wdata = count_dec;
            // A slot whose count drops to zero goes back to the tail unless
            // the list is already full.
            if (count_dec == '0 && free_fill < FILL_W'(POOL_SIZE)) begin
              free_we        = 1'b1;
              free_tail_next = next_pos(free_tail);
              free_fill_next = free_fill + 1'b1;
            end
          end
        end
      end
      default: begin
        status_next = ST_FAIL;
      end
    endcase
  end

  // Memories: read at request acceptance, written at the end of the pass.
  always_ff @(posedge clk) begin
    if (accept) begin
      free_rdata  <= free_mem[free_head];
      count_rdata <= count_mem[slot_index[IDX_W-1:0]];
    end
    if (busy && free_we) begin
      free_mem[free_tail] <= slot_idx;
    end
    if (busy && count_we) begin
      count_mem[count_waddr] <= count_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd;
      slot_q <= slot_index;
    end
    if (busy) begin
      status        <= status_next;
      granted_index <= granted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      done               <= 1'b0;
      zero_release_error <= 1'b0;
      free_head          <= '0;
      free_tail          <= '0;
      free_fill          <= FILL_W'(POOL_SIZE);
      free_valid         <= '0;
      count_valid        <= '0;
      free_rvalid        <= 1'b0;
      count_rvalid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        zero_release_error <= cfg_data;
      end
      if (accept) begin
        free_rvalid  <= free_valid[free_head];
        count_rvalid <= count_valid[slot_index[IDX_W-1:0]];
      end
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          done      <= 1'b1;
          state     <= S_IDLE;
          free_head <= free_head_next;
          free_tail <= free_tail_next;
          free_fill <= free_fill_next;
          if (free_we) begin
            free_valid[free_tail] <= 1'b1;
          end
          if (count_we) begin
            count_valid[count_waddr] <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    free_fill <= FILL_W'(POOL_SIZE))
    else $error("free list fill count exceeds pool size");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy ##1 (done && !busy)))
    else $error("accepted request did not give exactly one result");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    (done && granted_index != '0) |-> (status == ST_OK))
    else $error("nonzero granted index on a failed request");
`endif

endmodule
